[hw/rtl/probe_overlap_assembly_scorer_core_defines.svh]
// Assertion macros used by the RTL core.
`ifndef PROBE_OVERLAP_ASSEMBLY_SCORER_CORE_DEFINES_SVH
`define PROBE_OVERLAP_ASSEMBLY_SCORER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define POAS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define POAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define POAS_ASSERT_SAME(label, clk, rst, ante, cons)
`define POAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/poas_pkg.sv]
package poas_pkg;

  localparam int MAX_PROBE_BASES = 32;
  localparam int TAIL_BASES      = 31;
  localparam int PROBE_W         = 2 * MAX_PROBE_BASES;
  localparam int TAIL_W          = 2 * TAIL_BASES;

  localparam logic [5:0]  PLEN_RESET          = 6'd10;
  localparam logic [15:0] TARGET_LENGTH_RESET = 16'd200;

  // Configuration register indexes.
  localparam logic CFG_PLEN          = 1'b0;
  localparam logic CFG_TARGET_LENGTH = 1'b1;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [20:0] SUM_MAX   = 21'h1FFFFF;

  typedef struct packed {
    logic [3:0]  pad;
    logic        halted;
    logic [20:0] fitness_score;
    logic [15:0] oligo_count;
    logic [15:0] assembled_length;
    logic        appended;
    logic [4:0]  overlap_found;
  } result_t;

endpackage

[hw/rtl/poas_overlap.sv]
module poas_overlap
  import poas_pkg::*;
(
  input  logic [TAIL_W-1:0]  tail,
  input  logic [PROBE_W-1:0] probe,
  input  logic [5:0]         plen,
  input  logic [15:0]        len,
  output logic [4:0]         overlap
);

  logic [TAIL_BASES-1:0] hit;

  // One comparator per overlap length: the k newest bases against the first k probe bases.
  for (genvar k = 1; k <= TAIL_BASES; k++) begin : g_cmp
    assign hit[k-1] = (6'(k) < plen) && (16'(k) <= len) &&
                      (tail[TAIL_W-1 -: 2*k] == probe[2*k-1:0]);
  end

  always_comb begin
    overlap = '0;
    for (int k = 1; k <= TAIL_BASES; k++) begin
      if (hit[k-1]) begin
        overlap = 5'(k);
      end
    end
  end

endmodule

[hw/rtl/probe_overlap_assembly_scorer_core.sv]
// An accepted input item passes through the input register, then the result
// register, before its result appears on the master side.
// Throughput: one item per cycle unless stalled; the overlap search, length check
// and tail update all resolve in the single logic stage between the two registers.
// Reset (synchronous, active high) empties both stages, clears the assembly state
// and returns the probe length to 10 and target_length to 200.
`include "probe_overlap_assembly_scorer_core_defines.svh"

module probe_overlap_assembly_scorer_core
  import poas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // probe_bases[63:0]
  input  logic        s_tuser,   // first_item
  output logic        m_tvalid,
  input  logic        m_tready,
  // overlap_found[4:0], appended[5], assembled_length[21:6], oligo_count[37:22],
  // fitness_score[58:38], halted[59], zero[63:60]
  output logic [63:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [5:0]  plen_cfg;
  logic [15:0] target_length;

  logic               in_valid;
  logic [PROBE_W-1:0] in_probe;
  logic               in_first;

  logic [TAIL_W-1:0] tail_window;
  logic [15:0]       length_so_far;
  logic [15:0]       count_so_far;
  logic [20:0]       overlap_sum;
  logic              stop_flag;

  result_t result;

  logic [TAIL_W-1:0] tail_window_next;
  logic [15:0]       length_so_far_next;
  logic [15:0]       count_so_far_next;
  logic [20:0]       overlap_sum_next;
  logic              stop_flag_next;
  result_t           result_next;

  logic               adv;
  logic [5:0]         plen;
  logic [PROBE_W-1:0] pmask;
  logic [PROBE_W-1:0] probe_m;
  logic [4:0]         ov_found;
  logic [4:0]         ov_use;
  logic [5:0]         fresh_bases;
  logic [16:0]        new_len;
  logic               fits;
  logic [PROBE_W-1:0] fresh;
  logic [TAIL_W-1:0]  tail_base;
  logic [PROBE_W+TAIL_W-1:0] joined;
  logic [PROBE_W+TAIL_W-1:0] joined_sh;
  logic [21:0]        sum_wide;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      plen_cfg      <= PLEN_RESET;
      target_length <= TARGET_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLEN:          plen_cfg      <= cfg_data[5:0];
        CFG_TARGET_LENGTH: target_length <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_probe <= s_tdata;
      in_first <= s_tuser;
    end
  end

  assign plen = (plen_cfg > 6'(MAX_PROBE_BASES)) ? 6'(MAX_PROBE_BASES) : plen_cfg;

  always_comb begin
    for (int i = 0; i < MAX_PROBE_BASES; i++) begin
      pmask[2*i +: 2] = {2{6'(i) < plen}};
    end
  end

  assign probe_m = in_probe & pmask;

  poas_overlap u_overlap (
    .tail    (tail_window),
    .probe   (probe_m),
    .plen    (plen),
    .len     (length_so_far),
    .overlap (ov_found)
  );

  assign ov_use      = in_first ? 5'd0 : ov_found;
  assign fresh_bases = plen - {1'b0, ov_use};
  assign new_len     = {1'b0, length_so_far} + {11'd0, fresh_bases};
  assign fits        = new_len <= {1'b0, target_length};

  // The new bases enter above the old tail; shifting the joined word down by the
  // number of new bases leaves the newest bases at the top of the window.
  assign fresh     = probe_m >> {ov_use, 1'b0};
  assign tail_base = in_first ? '0 : tail_window;
  assign joined    = {fresh, tail_base};
  assign joined_sh = joined >> {fresh_bases, 1'b0};
  assign sum_wide  = {1'b0, overlap_sum} + {17'd0, ov_found};

  always_comb begin
    tail_window_next   = tail_window;
    length_so_far_next = length_so_far;
    count_so_far_next  = count_so_far;
    overlap_sum_next   = overlap_sum;
    stop_flag_next     = stop_flag;
    result_next        = '0;
    if (in_first) begin
      tail_window_next   = joined_sh[TAIL_W-1:0];
      length_so_far_next = {10'd0, plen};
      count_so_far_next  = 16'd1;
      overlap_sum_next   = '0;
      stop_flag_next     = 1'b0;
      result_next.appended = 1'b1;
    end else if (count_so_far != '0 && !stop_flag) begin
      result_next.overlap_found = ov_found;
      if (fits) begin
        tail_window_next   = joined_sh[TAIL_W-1:0];
        length_so_far_next = new_len[15:0];
        count_so_far_next  = (count_so_far == COUNT_MAX) ? COUNT_MAX : count_so_far + 16'd1;
        overlap_sum_next   = sum_wide[21] ? SUM_MAX : sum_wide[20:0];
        result_next.appended = 1'b1;
      end else begin
        stop_flag_next = 1'b1;
      end
    end
    result_next.assembled_length = length_so_far_next;
    result_next.oligo_count      = count_so_far_next;
    result_next.fitness_score    = overlap_sum_next;
    result_next.halted           = stop_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_window   <= '0;
      length_so_far <= '0;
      count_so_far  <= '0;
      overlap_sum   <= '0;
      stop_flag     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else if (adv) begin
      tail_window   <= tail_window_next;
      length_so_far <= length_so_far_next;
      count_so_far  <= count_so_far_next;
      overlap_sum   <= overlap_sum_next;
      stop_flag     <= stop_flag_next;
      m_tvalid      <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (adv) begin
      result <= result_next;
    end
  end

  assign m_tdata = result;

  `POAS_ASSERT_NEXT(a_halt_holds, clk, rst, adv && !in_first && stop_flag, stop_flag)
  `POAS_ASSERT_NEXT(a_no_eval_idle, clk, rst, adv && !in_first && count_so_far == '0,
                    count_so_far == '0)
  `POAS_ASSERT_NEXT(a_start_opens, clk, rst, adv && in_first,
                    count_so_far == 16'd1 && !stop_flag && overlap_sum == '0)

endmodule

[tb/probe_overlap_assembly_scorer_core_tb.sv]
`timescale 1ns / 100ps

module probe_overlap_assembly_scorer_core_tb
  import poas_pkg::*;
();

  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 80;

  // Tracks the assembly as the block should see it and holds the scores still owed.
  class assembly_tracker;
    logic [5:0]  probe_len_reg;
    logic [15:0] target_reg;
    logic [61:0] tail;
    int          asm_len;
    int          oligos;
    int          overlap_total;
    bit          halted;
    result_t     pending_scores[$];
    int          mismatches;

    function new();
      probe_len_reg = PLEN_RESET;
      target_reg    = TARGET_LENGTH_RESET;
      tail          = '0;
      asm_len       = 0;
      oligos        = 0;
      overlap_total = 0;
      halted        = 1'b0;
      mismatches    = 0;
    endfunction

    function logic [63:0] mask_bits(int bits);
      if (bits >= 64) return '1;
      return (64'd1 << bits) - 64'd1;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == CFG_PLEN) probe_len_reg = val[5:0];
      else target_reg = val;
    endfunction

    // The newest base sits in the top two bits of the tail.
    function void shift_in(logic [63:0] probe, int plen, int ov);
      int          m;
      logic [63:0] fresh;
      m = plen - ov;
      if (m >= TAIL_BASES) begin
        tail = 62'(probe >> (2 * (plen - TAIL_BASES)));
      end else begin
        fresh = (probe >> (2 * ov)) & mask_bits(2 * m);
        tail = 62'(({2'b00, tail} >> (2 * m)) | (fresh << (2 * (TAIL_BASES - m))));
      end
    endfunction

    function void note_probe(logic [63:0] bases, bit first);
      int          plen;
      int          ov;
      logic [63:0] probe;
      logic [63:0] suffix;
      result_t     r;
      plen = int'(probe_len_reg);
      if (plen > MAX_PROBE_BASES) plen = MAX_PROBE_BASES;
      probe = bases & mask_bits(2 * plen);
      ov = 0;
      r = '0;
      if (first) begin
        tail = '0;
        shift_in(probe, plen, 0);
        asm_len       = plen;
        oligos        = 1;
        overlap_total = 0;
        halted        = 1'b0;
        r.appended    = 1'b1;
      end else if (oligos != 0 && !halted) begin
        // Longest overlap wins; overlaps longer than the assembly are skipped.
        for (int k = plen - 1; k > 0; k--) begin
          suffix = {2'b00, tail} >> (2 * (TAIL_BASES - k));
          if (ov == 0 && k <= TAIL_BASES && k <= asm_len &&
              (suffix & mask_bits(2 * k)) == (probe & mask_bits(2 * k)))
            ov = k;
        end
        if (asm_len + plen - ov <= target_reg) begin
          shift_in(probe, plen, ov);
          asm_len += plen - ov;
          if (oligos < COUNT_MAX) oligos++;
          overlap_total += ov;
          if (overlap_total > SUM_MAX) overlap_total = int'(SUM_MAX);
          r.appended = 1'b1;
        end else begin
          halted = 1'b1;
        end
      end
      r.overlap_found    = 5'(ov);
      r.assembled_length = 16'(asm_len);
      r.oligo_count      = 16'(oligos);
      r.fitness_score    = 21'(overlap_total);
      r.halted           = halted;
      pending_scores.insert(pending_scores.size(), r);
    endfunction

    function void check_score(logic [63:0] data);
      result_t got;
      result_t want;
      bit      bad;
      got = result_t'(data);
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("score item with none expected: %h", data);
        return;
      end
      want = pending_scores.pop_front();
      bad = (got.overlap_found !== want.overlap_found) ||
            (got.appended !== want.appended) ||
            (got.assembled_length !== want.assembled_length) ||
            (got.oligo_count !== want.oligo_count) ||
            (got.fitness_score !== want.fitness_score) ||
            (got.halted !== want.halted) ||
            (got.pad !== 4'd0);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("score mismatch: exp ov=%0d app=%0d len=%0d cnt=%0d fit=%0d halt=%0d pad=0",
                   want.overlap_found, want.appended, want.assembled_length,
                   want.oligo_count, want.fitness_score, want.halted);
          $display("                got ov=%0d app=%0d len=%0d cnt=%0d fit=%0d halt=%0d pad=%0d",
                   got.overlap_found, got.appended, got.assembled_length,
                   got.oligo_count, got.fitness_score, got.halted, got.pad);
        end
      end
    endfunction

    function int scores_waiting();
      return pending_scores.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  assembly_tracker sb = new();

  int cycle_count = 0;
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;
  bit rx_hold_req = 1'b0;
  int gen_plen    = 10;

  probe_overlap_assembly_scorer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("end of test: mismatches");
    $finish;
  end

  // Values read here are those the block sampled at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_probe(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_score(m_tdata);
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Score receiver: random stalls, plus one long hold-off when asked.
  initial begin
    int w;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        w = LONG_HOLD;
        rx_hold_req = 1'b0;
      end else begin
        w = rx_burst ? 0 : $urandom_range(0, 5);
      end
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  task automatic send_item(logic [63:0] bases, bit first);
    int w;
    w = tx_burst ? 0 : $urandom_range(0, 5);
    if (w > 0) begin
      s_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= bases;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Polling on the falling edge sees every score noted at the preceding rising edge.
  task automatic drain_scores();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.scores_waiting() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(int plen_val, int target_val);
    logic [15:0] d;
    drain_scores();
    d = 16'($urandom);
    d[5:0] = 6'(plen_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PLEN;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= CFG_TARGET_LENGTH;
    cfg_data  <= 16'(target_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_plen = plen_val & 63;
    if (gen_plen > MAX_PROBE_BASES) gen_plen = MAX_PROBE_BASES;
  endtask

  // Two-letter and single-letter probes produce long self-overlaps.
  function automatic logic [63:0] rand_bases();
    logic [63:0] p;
    p = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: p = p & 64'h5555_5555_5555_5555;
      2: p = {32{p[1:0]}};
      default: ;
    endcase
    return p;
  endfunction

  // Mostly chains where each probe starts with the tail of the one before it,
  // mixed with stray probes, stray start flags and chains that run on.
  task automatic run_phase(int n_items, bit no_gaps);
    int          sent;
    int          run_left;
    int          k;
    int          style;
    logic [63:0] p;
    logic [63:0] prev;
    sent = 0;
    run_left = 0;
    prev = rand_bases();
    tx_burst = no_gaps || ($urandom_range(0, 3) == 0);
    while (sent < n_items) begin
      style = $urandom_range(0, 19);
      p = rand_bases();
      if (run_left == 0 && style != 0) begin
        send_item(p, 1'b1);
        run_left = $urandom_range(1, 30);
      end else if (style == 1) begin
        send_item(p, 1'($urandom_range(0, 1)));
      end else begin
        k = (gen_plen > 1) ? $urandom_range(0, gen_plen - 1) : 0;
        if (k > 0)
          p = (p & ~sb.mask_bits(2 * k)) | ((prev >> (2 * (gen_plen - k))) & sb.mask_bits(2 * k));
        send_item(p, 1'b0);
        if (run_left > 0) run_left--;
      end
      prev = p;
      sent++;
    end
  endtask

  initial begin
    int phase_plen [14];
    int eff;
    int target;
    phase_plen = '{10, 32, 2, 31, 63, 5, 16, 0, 20, 3, 33, 32, 8, 1};
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PLEN;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings. No evaluation is open yet, so the first probe is ignored.
    send_item('1, 1'b0);
    send_item('1, 1'b1);
    send_item('1, 1'b0);
    send_item('0, 1'b0);
    send_item({$urandom, $urandom}, 1'b0);

    // Fill up to the target, get rejected, stay halted, then restart.
    set_config(4, 10);
    send_item(64'h0, 1'b1);
    send_item(64'hFF, 1'b0);
    send_item(64'h55, 1'b0);
    send_item(64'h0, 1'b0);
    send_item(64'hE4, 1'b1);

    // Zero and one base probes give no overlaps.
    set_config(0, 0);
    send_item({$urandom, $urandom}, 1'b1);
    send_item({$urandom, $urandom}, 1'b0);
    set_config(1, 1);
    send_item({$urandom, $urandom}, 1'b1);
    send_item({$urandom, $urandom}, 1'b0);
    send_item({$urandom, $urandom}, 1'b0);

    // An oversized length saturates; identical probes give the longest overlap.
    set_config(63, 65535);
    send_item('1, 1'b1);
    send_item('1, 1'b0);

    // Raising the length mid-evaluation limits the overlap to the assembly.
    set_config(2, 65535);
    send_item('0, 1'b1);
    set_config(20, 65535);
    send_item('0, 1'b0);

    for (int i = 0; i < 14; i++) begin
      eff = (phase_plen[i] & 63) > MAX_PROBE_BASES ? MAX_PROBE_BASES : (phase_plen[i] & 63);
      case ($urandom_range(0, 3))
        0: target = $urandom_range(0, eff * 6 + 4);
        1: target = $urandom_range(eff * 6, eff * 40 + 8);
        2: target = 65535;
        default: target = $urandom_range(0, 65535);
      endcase
      if (i == 2) target = 1;
      if (i == 11) target = 65535;
      set_config(phase_plen[i], target);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (i == 3) begin
        run_phase(60, 1'b0);
        // Hold the output off while probes keep coming so the input stalls.
        rx_hold_req = 1'b1;
        run_phase(40, 1'b1);
        run_phase(40, 1'b0);
      end else if (i == 6) begin
        run_phase(70, 1'b0);
        drain_scores();
        run_phase(70, 1'b0);
      end else begin
        run_phase(140, 1'b0);
      end
    end

    drain_scores();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.scores_waiting() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
